// ===== sv/min_priority_queue_core_macros.svh =====
// Assertion macros for the priority queue core.
// Both forms are clocked on the rising edge and disabled while reset is low.
`ifndef MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/mpq_pkg.sv =====
`timescale 1ns / 1ps
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    typedef enum logic
    {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // what one cell hands to its right neighbor
    typedef struct packed
    {
        entry_t data;
        logic   shift;
    } link_t;

    // per-cell control from the top level
    typedef struct packed
    {
        logic push;
        logic pop;
        logic occ;
        logic at_tail;
    } cell_ctrl_t;

endpackage

// ===== sv/min_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Sorted min-priority queue of key/value pairs, built as a row of CAPACITY
// cells that each hold one pair. A push compares its key against every cell
// at once and the cells past the insertion point shift right by one; a pop
// shifts every cell left. A command is taken in any cycle (busy stays low),
// so the queue sustains one push or pop per clock. Its result is registered
// onto the output ports at the accepting edge, marked by done,
// and cannot be held off. Equal keys leave in push order. A pop on an empty
// queue or a push on a full one changes nothing and reports it in status.
`include "min_priority_queue_core_macros.svh"
module min_priority_queue_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [31:0]                entry_key,
    input  logic [31:0]                entry_value,
    output logic                       done,
    output logic [31:0]                popped_key,
    output logic [31:0]                popped_value,
    output logic [31:0]                head_key,
    output logic [31:0]                head_value,
    output logic                       nonempty,
    output logic [mpq_pkg::CNT_W-1:0]  fill_count,
    output logic [1:0]                 status
);

    localparam int N = mpq_pkg::CAPACITY;

    logic                      accept;
    logic                      is_pop;
    logic                      empty;
    logic                      full;
    logic                      do_push;
    logic                      do_pop;
    logic [mpq_pkg::CNT_W-1:0] count_reg;
    logic [mpq_pkg::CNT_W-1:0] count_next;
    logic                      done_reg;
    logic [31:0]               popped_key_reg;
    logic [31:0]               popped_key_next;
    logic [31:0]               popped_value_reg;
    logic [31:0]               popped_value_next;
    mpq_pkg::status_t          status_reg;
    mpq_pkg::status_t          status_next;
    mpq_pkg::entry_t           new_entry;
    mpq_pkg::link_t            links [N];
    mpq_pkg::cell_ctrl_t       ctrl  [N];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_pop    = (mpq_pkg::action_t'(action) == mpq_pkg::ACT_POP);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == mpq_pkg::CNT_W'(N));
    assign do_push   = accept && !is_pop && !full;
    assign do_pop    = accept && is_pop && !empty;
    assign new_entry = '{key: entry_key, value: entry_value};

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            assign ctrl[gi] = '{push:    do_push,
                                pop:     do_pop,
                                occ:     (count_reg > mpq_pkg::CNT_W'(gi)),
                                at_tail: (count_reg == mpq_pkg::CNT_W'(gi))};

            if (gi == 0)
            begin : g_first
                mpq_cell u_cell
                (
                    .clk       (clk),
                    .ctrl      (ctrl[gi]),
                    .new_entry (new_entry),
                    .left      ('0),
                    .right     (links[gi+1].data),
                    .out       (links[gi])
                );
            end
            else if (gi == N - 1)
            begin : g_last
                // vacated on a pop, so its own data is as good as any
                mpq_cell u_cell
                (
                    .clk       (clk),
                    .ctrl      (ctrl[gi]),
                    .new_entry (new_entry),
                    .left      (links[gi-1]),
                    .right     (links[gi].data),
                    .out       (links[gi])
                );
            end
            else
            begin : g_mid
                mpq_cell u_cell
                (
                    .clk       (clk),
                    .ctrl      (ctrl[gi]),
                    .new_entry (new_entry),
                    .left      (links[gi-1]),
                    .right     (links[gi+1].data),
                    .out       (links[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next        = count_reg;
        popped_key_next   = '0;
        popped_value_next = '0;
        status_next       = mpq_pkg::ST_OK;
        if (accept)
        begin
            if (is_pop)
            begin
                if (empty)
                begin
                    status_next = mpq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    popped_key_next   = links[0].data.key;
                    popped_value_next = links[0].data.value;
                    count_next        = count_reg - 1'b1;
                end
            end
            else if (full)
            begin
                status_next = mpq_pkg::ST_PUSH_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= mpq_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_key_reg   <= popped_key_next;
        popped_value_reg <= popped_value_next;
    end

    assign done         = done_reg;
    assign popped_key   = popped_key_reg;
    assign popped_value = popped_value_reg;
    assign head_key     = empty ? '0 : links[0].data.key;
    assign head_value   = empty ? '0 : links[0].data.value;
    assign nonempty     = !empty;
    assign fill_count   = count_reg;
    assign status       = status_reg;

    `MPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= mpq_pkg::CNT_W'(N), "fill count past capacity")
    `MPQ_ASSERT_NXT(a_done_follows, clk, rst_n, accept, done, "no result beat for command")
    `MPQ_ASSERT_NXT(a_no_spurious, clk, rst_n, !accept, !done, "result beat without command")
    `MPQ_ASSERT_NXT(a_pop_count, clk, rst_n, do_pop,
        fill_count == $past(count_reg) - 1'b1 && status == mpq_pkg::ST_OK,
        "pop did not remove one entry")
    `MPQ_ASSERT_IMP(a_sorted_head, clk, rst_n, count_reg >= mpq_pkg::CNT_W'(2),
        links[0].data.key <= links[1].data.key, "head entry out of order")

endmodule

// ===== sv/mpq_cell.sv =====
`timescale 1ns / 1ps
module mpq_cell
(
    input  logic               clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::entry_t    new_entry,
    input  mpq_pkg::link_t     left,
    input  mpq_pkg::entry_t    right,
    output mpq_pkg::link_t     out
);

    mpq_pkg::entry_t data_reg;
    mpq_pkg::entry_t data_next;
    logic            moves;

    // Slot lies at or past the insertion point: held key strictly greater
    // (ties stay ahead), or the first free slot.
    assign moves = ctrl.occ ? (data_reg.key > new_entry.key) : ctrl.at_tail;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push && moves)
        begin
            data_next = left.shift ? left.data : new_entry;
        end
        else if (ctrl.pop)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out = '{data: data_reg, shift: moves};

endmodule
